[rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = ROWS * COLS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CPOS_W = $clog2(COLS);
  localparam int RPOS_W = $clog2(ROWS);
  localparam int CX_W   = $clog2(COLS + TAB_STEP);
  localparam int RY_W   = $clog2(ROWS + 1);

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int RSEL_W = 5;
  localparam int CSEL_W = 7;
  localparam int CELL_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [RSEL_W-1:0] cell_row;
    logic [CSEL_W-1:0] cell_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [CSEL_W-1:0] cursor_col;
    logic [RSEL_W-1:0] cursor_row;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

[rtl/tcw_in_if.sv]
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [RSEL_W-1:0] cell_row;
  logic [CSEL_W-1:0] cell_col;

  modport source (output valid, output func, output char_code, output cell_row,
                  output cell_col, input ready);
  modport sink (input valid, input func, input char_code, input cell_row,
                input cell_col, output ready);
endinterface

`default_nettype wire

[rtl/tcw_out_if.sv]
`default_nettype none

interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_data;
  logic [CSEL_W-1:0] cursor_col;
  logic [RSEL_W-1:0] cursor_row;
  logic              scrolled;

  modport source (output valid, output cell_data, output cursor_col,
                  output cursor_row, output scrolled, input ready);
  modport sink (input valid, input cell_data, input cursor_col,
                input cursor_row, input scrolled, output ready);
endinterface

`default_nettype wire

[rtl/tcw_cfg_if.sv]
`default_nettype none

interface tcw_cfg_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer: an 80 x 25 store of 16-bit cells (attribute high byte,
// character low byte) plus a cursor, driven by one command channel.
// in_i carries one command per beat: put character, read cell or clear screen.
// out_o returns exactly one result beat per command: the cell read (zero for
// other commands and off-screen reads), the cursor after the command and a scroll flag.
// cfg_i writes the attribute byte used by puts, clears and scroll blanking; it
// is always ready and is meant to be written while no command is in flight.
// A put without scroll, a read or an unused command goes from idle to the
// done state, which loads its result into the output register once that is
// free, and back to idle for the next command. A put that scrolls and a clear
// sweep the cell store (one write, one read port) one cell per cycle through
// the shared address counter. in_i.ready is low while a command is in work.
// Reset homes the cursor, sets the attribute to 0x0F and starts a clearing
// pass that fills every cell with 0x0F20; in_i.ready stays low until
// it ends. A finished result waits in the output register while out_o.ready
// is low, and the block accepts the next command meanwhile, holding that
// command's result until the register frees up.
`default_nettype none

module text_console_writer (
  input  logic            clk_i,
  input  logic            rst_ni,
  tcw_in_if.sink          in_i,
  tcw_out_if.source       out_o,
  tcw_cfg_if.sink         cfg_i
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  logic              out_valid_q;
  result_t           out_q;

  item_t             item;
  result_t           res;
  logic              res_valid;
  logic              res_ready;
  wr_req_t           wr;
  rd_req_t           rd;
  logic [CELL_W-1:0] rd_data;

  assign item.func      = in_i.func;
  assign item.char_code = in_i.char_code;
  assign item.cell_row  = in_i.cell_row;
  assign item.cell_col  = in_i.cell_col;

  assign res_ready = !out_valid_q || out_o.ready;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .attr_i      (attr_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .wr_o        (wr),
    .rd_o        (rd),
    .rd_data_i   (rd_data)
  );

  tcw_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_i.valid) begin
      attr_q <= cfg_i.data;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_data  = out_q.cell_data;
  assign out_o.cursor_col = out_q.cursor_col;
  assign out_o.cursor_row = out_q.cursor_row;
  assign out_o.scrolled   = out_q.scrolled;

  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over an unread beat");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (wr.addr < ADDR_W'(CELLS)))
    else $error("cell write outside the store");

  a_no_accept_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !wr.en)
    else $error("command accepted while a cell write is pending");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (8'(out_o.cursor_col) < 8'(COLS)))
    else $error("cursor column out of range");

endmodule

`default_nettype wire

[rtl/tcw_ram.sv]
`default_nettype none

module tcw_ram (
  input  logic                      clk_i,
  input  tcw_pkg::wr_req_t          wr_i,
  input  tcw_pkg::rd_req_t          rd_i,
  output logic [tcw_pkg::CELL_W-1:0] rd_data_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [CELLS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem_q[rd_i.addr];
    end
  end

endmodule

`default_nettype wire

[rtl/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tcw_pkg::item_t             item_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attr_i,
  input  logic                       res_ready_i,
  output logic                       res_valid_o,
  output tcw_pkg::result_t           res_o,
  output tcw_pkg::wr_req_t           wr_o,
  output tcw_pkg::rd_req_t           rd_o,
  input  logic [tcw_pkg::CELL_W-1:0] rd_data_i
);
  import tcw_pkg::*;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CPOS_W-1:0] col_q, col_d;
  logic [RPOS_W-1:0] row_q, row_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic              copy_q, copy_d;
  logic              init_q, init_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic              hit_q, hit_d;
  logic              scr_q, scr_d;
  logic              pend_v_q, pend_v_d;
  logic              pend_rd_q, pend_rd_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [CELL_W-1:0] pend_data_q, pend_data_d;

  logic              accept;
  logic              copy_phase;
  logic [ADDR_W-1:0] cur_addr;
  logic [CELL_W-1:0] blank;
  logic [CX_W-1:0]   col_x;
  logic [RY_W-1:0]   row_x;

  assign in_ready_o = (state_q == ST_IDLE) && !pend_v_q;
  assign accept     = in_valid_i && in_ready_o;
  assign blank      = {attr_i, CH_SPACE};
  assign cur_addr   = ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(col_q);
  assign copy_phase = copy_q && (k_q < ADDR_W'(CELLS - COLS));

  // single write port fed from the pending write stage
  assign wr_o.en   = pend_v_q;
  assign wr_o.addr = pend_addr_q;
  assign wr_o.data = pend_rd_q ? rd_data_i : pend_data_q;

  assign res_o.cell_data  = hit_q ? rd_data_i : '0;
  assign res_o.cursor_col = CSEL_W'(col_q);
  assign res_o.cursor_row = RSEL_W'(row_q);
  assign res_o.scrolled   = scr_q;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    k_d         = k_q;
    copy_d      = copy_q;
    init_d      = init_q;
    fill_d      = fill_q;
    hit_d       = hit_q;
    scr_d       = scr_q;
    pend_v_d    = 1'b0;
    pend_rd_d   = 1'b0;
    pend_addr_d = pend_addr_q;
    pend_data_d = pend_data_q;
    rd_o.en     = 1'b0;
    rd_o.addr   = '0;
    res_valid_o = 1'b0;
    col_x       = CX_W'(col_q);
    row_x       = RY_W'(row_q);

    case (state_q)
      ST_SWEEP: begin
        // one cell per cycle: copy from the row below or write the fill value
        rd_o.en     = copy_phase;
        rd_o.addr   = k_q + ADDR_W'(COLS);
        pend_v_d    = 1'b1;
        pend_rd_d   = copy_phase;
        pend_addr_d = k_q;
        pend_data_d = fill_q;
        k_d         = k_q + 1'b1;
        if (k_q == ADDR_W'(CELLS - 1)) begin
          state_d = init_q ? ST_IDLE : ST_DONE;
          init_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          hit_d   = 1'b0;
          scr_d   = 1'b0;
          state_d = ST_DONE;
          case (item_i.func)
            FUNC_PUT: begin
              if (item_i.char_code == CH_LF) begin
                col_x = '0;
                row_x = row_x + 1'b1;
              end else if (item_i.char_code == CH_CR) begin
                col_x = '0;
              end else if (item_i.char_code == CH_TAB) begin
                col_x = col_x + CX_W'(TAB_STEP);
              end else begin
                pend_v_d    = 1'b1;
                pend_addr_d = cur_addr;
                pend_data_d = {attr_i, item_i.char_code};
                col_x       = col_x + 1'b1;
              end
              if (col_x >= CX_W'(COLS)) begin
                col_x = '0;
                row_x = row_x + 1'b1;
              end
              col_d = CPOS_W'(col_x);
              row_d = RPOS_W'(row_x);
              if (row_x >= RY_W'(ROWS)) begin
                row_d   = RPOS_W'(ROWS - 1);
                scr_d   = 1'b1;
                fill_d  = blank;
                copy_d  = 1'b1;
                k_d     = '0;
                state_d = ST_SWEEP;
              end
            end
            FUNC_READ: begin
              if ((8'(item_i.cell_row) < 8'(ROWS)) && (8'(item_i.cell_col) < 8'(COLS))) begin
                hit_d     = 1'b1;
                rd_o.en   = 1'b1;
                rd_o.addr = ADDR_W'(item_i.cell_row) * ADDR_W'(COLS)
                          + ADDR_W'(item_i.cell_col);
              end
            end
            FUNC_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              fill_d  = blank;
              copy_d  = 1'b0;
              k_d     = '0;
              state_d = ST_SWEEP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        res_valid_o = res_ready_i;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      col_q    <= '0;
      row_q    <= '0;
      k_q      <= '0;
      copy_q   <= 1'b0;
      init_q   <= 1'b1;
      fill_q   <= CELL_RESET;
      hit_q    <= 1'b0;
      scr_q    <= 1'b0;
      pend_v_q <= 1'b0;
      pend_rd_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      k_q      <= k_d;
      copy_q   <= copy_d;
      init_q   <= init_d;
      fill_q   <= fill_d;
      hit_q    <= hit_d;
      scr_q    <= scr_d;
      pend_v_q <= pend_v_d;
      pend_rd_q <= pend_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
  end

endmodule

`default_nettype wire
